### src/tcet_pkg.sv
// ----------------------------------------------------------------------------
// tcet_pkg: shared types and constants for the tricorn escape-time pixel
// Q4.28 coordinate format, controller/datapath command bundles, saturation
// and the 16-entry color palette.
// ----------------------------------------------------------------------------
package tcet_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = COORD_W - 4;
    localparam int PIX_W   = 12;
    localparam int ITER_W  = 10;
    localparam int SIZE_W  = 13;
    localparam int STEP_W  = 31;
    localparam int WIDE_W  = 48;
    localparam int REL_W   = SIZE_W + 2;
    localparam int MAPP_W  = REL_W + COORD_W;

    localparam logic signed [WIDE_W-1:0] Q_MAX_W = WIDE_W'(64'sh7FFF_FFFF);
    localparam logic signed [WIDE_W-1:0] Q_MIN_W = -Q_MAX_W - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] ESCAPE_LIMIT = WIDE_W'(64'sd4 <<< FRAC_W);

    typedef struct packed {
        logic load;
        logic map_mul;
        logic map_add;
        logic iter_mul;
        logic iter_upd;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic at_limit;
        logic escape;
    } status_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > Q_MAX_W) begin
            r = Q_MAX_W[COORD_W-1:0];
        end else if (v < Q_MIN_W) begin
            r = Q_MIN_W[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    // {red, green, blue}
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] c;
        case (idx)
            4'd0:    c = {8'd66,  8'd30,  8'd15};
            4'd1:    c = {8'd25,  8'd7,   8'd26};
            4'd2:    c = {8'd9,   8'd1,   8'd47};
            4'd3:    c = {8'd4,   8'd4,   8'd73};
            4'd4:    c = {8'd0,   8'd7,   8'd100};
            4'd5:    c = {8'd12,  8'd44,  8'd138};
            4'd6:    c = {8'd24,  8'd82,  8'd177};
            4'd7:    c = {8'd57,  8'd125, 8'd209};
            4'd8:    c = {8'd134, 8'd181, 8'd229};
            4'd9:    c = {8'd211, 8'd236, 8'd248};
            4'd10:   c = {8'd241, 8'd233, 8'd191};
            4'd11:   c = {8'd248, 8'd201, 8'd95};
            4'd12:   c = {8'd255, 8'd170, 8'd0};
            4'd13:   c = {8'd204, 8'd128, 8'd0};
            4'd14:   c = {8'd153, 8'd87,  8'd0};
            default: c = {8'd106, 8'd52,  8'd3};
        endcase
        return c;
    endfunction

endpackage

### src/tricorn_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// tricorn_escape_time_pixel: escape-time tricorn fractal pixel engine
// Maps each pixel to c, iterates z = conj(z)^2 + c and returns count and color.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one transaction per pixel, s_tdata = {pixel_y, pixel_x}.
//   m_ channel: one transaction per pixel, s_tdata fields passed through with
//   iteration count and RGB color; m_tuser carries the inside-set flag.
//   APB port: view center, pixel step, image size and iteration limit.
//   Write only while the engine is idle.
// Timing:
//   One pixel is worked at a time. Each iteration takes the multiplier
//   state, then the add/saturate/escape-test state. m_tvalid rises after
//   the pixel reaches its limit or escapes and the output register is
//   free. s_tready rises as the result enters the output register.
// Reset: state machine idles, output register empties, registers take their
//   default view (center 0, 800x800, limit 200).
// Stall: a result waits in the output register while m_tready is low; the
//   next pixel is accepted and computed meanwhile, then holds until free.
// ----------------------------------------------------------------------------
module tricorn_escape_time_pixel
    import tcet_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: [11:0] pixel_x, [23:12] pixel_y
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // m_tdata: [11:0] out_x, [23:12] out_y, [33:24] iteration_count,
    //          [41:34] red, [49:42] green, [57:50] blue, [63:58] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    // m_tuser: [0] inside_set
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] REG_CENTER_REAL = 3'd0;
    localparam logic [2:0] REG_CENTER_IMAG = 3'd1;
    localparam logic [2:0] REG_PIXEL_STEP  = 3'd2;
    localparam logic [2:0] REG_WIDTH       = 3'd3;
    localparam logic [2:0] REG_HEIGHT      = 3'd4;
    localparam logic [2:0] REG_MAX_ITER    = 3'd5;

    logic signed [COORD_W-1:0] center_real_reg, center_imag_reg;
    logic [STEP_W-1:0]         pixel_step_reg;
    logic [SIZE_W-1:0]         image_width_reg, image_height_reg;
    logic [ITER_W-1:0]         max_iter_reg;

    logic        cfg_write;
    logic [2:0]  cfg_idx;
    cmd_t        cmd;
    status_t     status;
    logic        out_free;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_inside_reg;

    logic [PIX_W-1:0]  res_x, res_y;
    logic [ITER_W-1:0] res_count;
    logic              res_inside;
    logic [23:0]       res_rgb;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_real_reg  <= '0;
            center_imag_reg  <= '0;
            pixel_step_reg   <= STEP_W'(1342177);
            image_width_reg  <= SIZE_W'(800);
            image_height_reg <= SIZE_W'(800);
            max_iter_reg     <= ITER_W'(200);
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_CENTER_REAL: center_real_reg  <= pwdata;
                REG_CENTER_IMAG: center_imag_reg  <= pwdata;
                REG_PIXEL_STEP:  pixel_step_reg   <= pwdata[STEP_W-1:0];
                REG_WIDTH:       image_width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT:      image_height_reg <= pwdata[SIZE_W-1:0];
                REG_MAX_ITER:    max_iter_reg     <= pwdata[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CENTER_REAL: prdata = center_real_reg;
            REG_CENTER_IMAG: prdata = center_imag_reg;
            REG_PIXEL_STEP:  prdata = 32'(pixel_step_reg);
            REG_WIDTH:       prdata = 32'(image_width_reg);
            REG_HEIGHT:      prdata = 32'(image_height_reg);
            REG_MAX_ITER:    prdata = 32'(max_iter_reg);
            default:         prdata = '0;
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    tcet_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    tcet_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .pixel_x        (s_tdata[11:0]),
        .pixel_y        (s_tdata[23:12]),
        .center_real    (center_real_reg),
        .center_imag    (center_imag_reg),
        .pixel_step     (pixel_step_reg),
        .image_width    (image_width_reg),
        .image_height   (image_height_reg),
        .iter_limit     (max_iter_reg),
        .res_x          (res_x),
        .res_y          (res_y),
        .res_count      (res_count),
        .res_inside     (res_inside),
        .res_rgb        (res_rgb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg  <= {6'd0, res_rgb[7:0], res_rgb[15:8], res_rgb[23:16],
                             res_count, res_y, res_x};
            m_inside_reg <= res_inside;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_inside_reg;

    a_inside_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[57:34] == 24'd0)
        else $error("inside pixel with nonzero color");

    a_inside_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit && res_inside |-> res_count == max_iter_reg)
        else $error("inside flag without reaching the limit");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid_reg || m_tready))
        else $error("result overwrote a pending transaction");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.map_mul |-> !s_tready)
        else $error("input accepted while mapping");

endmodule

### src/tcet_ctrl.sv
// ----------------------------------------------------------------------------
// tcet_ctrl: sequencing state machine
// Steps one pixel through mapping, the multiply/update iteration loop and
// the hand-off to the output register.
// ----------------------------------------------------------------------------
module tcet_ctrl
    import tcet_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_free,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP_MUL,
        ST_MAP_ADD,
        ST_ITER_MUL,
        ST_ITER_UPD,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL: begin
                cmd.map_mul = 1'b1;
                state_next  = ST_MAP_ADD;
            end
            ST_MAP_ADD: begin
                cmd.map_add = 1'b1;
                state_next  = ST_ITER_MUL;
            end
            ST_ITER_MUL: begin
                if (status.at_limit) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.iter_mul = 1'b1;
                    state_next   = ST_ITER_UPD;
                end
            end
            ST_ITER_UPD: begin
                if (status.escape) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.iter_upd = 1'b1;
                    state_next   = ST_ITER_MUL;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/tcet_dp.sv
// ----------------------------------------------------------------------------
// tcet_dp: coordinate mapping and tricorn iteration datapath
// Multiplies are registered; the following cycle shifts, adds and saturates,
// and in the iteration loop also tests for escape.
// ----------------------------------------------------------------------------
module tcet_dp
    import tcet_pkg::*;
(
    input  logic                       aclk,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic [PIX_W-1:0]           pixel_x,
    input  logic [PIX_W-1:0]           pixel_y,
    input  logic signed [COORD_W-1:0]  center_real,
    input  logic signed [COORD_W-1:0]  center_imag,
    input  logic [STEP_W-1:0]          pixel_step,
    input  logic [SIZE_W-1:0]          image_width,
    input  logic [SIZE_W-1:0]          image_height,
    input  logic [ITER_W-1:0]          iter_limit,
    output logic [PIX_W-1:0]           res_x,
    output logic [PIX_W-1:0]           res_y,
    output logic [ITER_W-1:0]          res_count,
    output logic                       res_inside,
    output logic [23:0]                res_rgb
);

    logic [PIX_W-1:0]          px_reg, py_reg;
    logic signed [MAPP_W-1:0]  prod_x_reg, prod_y_reg;
    logic signed [COORD_W-1:0] cr_reg, ci_reg;
    logic signed [COORD_W-1:0] a_reg, b_reg;
    logic [ITER_W-1:0]         count_reg;
    logic signed [63:0]        paa_reg, pbb_reg, pab_reg;

    logic signed [REL_W-1:0]   rel_x, rel_y;
    logic signed [WIDE_W-1:0]  a2, b2, nab2;
    logic signed [64:0]        neg_ab;
    logic signed [COORD_W-1:0] a_next, b_next;

    assign rel_x = $signed({2'b00, px_reg, 1'b0}) - $signed({2'b00, image_width});
    assign rel_y = $signed({2'b00, py_reg, 1'b0}) - $signed({2'b00, image_height});

    assign a2     = WIDE_W'(paa_reg >>> FRAC_W);
    assign b2     = WIDE_W'(pbb_reg >>> FRAC_W);
    // floor(-2ab / 2^28) == floor(-ab / 2^27)
    assign neg_ab = -(65'(pab_reg));
    assign nab2   = WIDE_W'(neg_ab >>> (FRAC_W - 1));

    assign a_next = sat_coord(a2 - b2 + WIDE_W'(cr_reg));
    assign b_next = sat_coord(nab2 + WIDE_W'(ci_reg));

    assign status.at_limit = (count_reg == iter_limit);
    assign status.escape   = (a2 + b2) > ESCAPE_LIMIT;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map_mul) begin
            prod_x_reg <= MAPP_W'(rel_x) * MAPP_W'($signed({1'b0, pixel_step}));
            prod_y_reg <= MAPP_W'(rel_y) * MAPP_W'($signed({1'b0, pixel_step}));
        end
        if (cmd.map_add) begin
            cr_reg    <= sat_coord(WIDE_W'(prod_x_reg >>> 1) + WIDE_W'(center_real));
            ci_reg    <= sat_coord(WIDE_W'(prod_y_reg >>> 1) + WIDE_W'(center_imag));
            a_reg     <= '0;
            b_reg     <= '0;
            count_reg <= '0;
        end
        if (cmd.iter_mul) begin
            paa_reg <= 64'(a_reg) * 64'(a_reg);
            pbb_reg <= 64'(b_reg) * 64'(b_reg);
            pab_reg <= 64'(a_reg) * 64'(b_reg);
        end
        if (cmd.iter_upd) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            count_reg <= count_reg + ITER_W'(1);
        end
    end

    assign res_x      = px_reg;
    assign res_y      = py_reg;
    assign res_count  = count_reg;
    assign res_inside = status.at_limit;
    assign res_rgb    = status.at_limit ? 24'd0 : palette_rgb(count_reg[3:0]);

endmodule
